FILE: rtl/pdud_pkg.sv
package pdud_pkg;

	// command codes of an input word
	localparam logic [1:0] CMD_CONT  = 2'd0;
	localparam logic [1:0] CMD_GEN   = 2'd1;
	localparam logic [1:0] CMD_MV    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [7:0] FLAG_PROB = 8'd252;
	localparam logic [7:0] MAX_DELTA = 8'd254;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] old_prob;
		logic       bit_req;
	} in_word_t;

	typedef struct packed {
		logic       done_res;
		logic [7:0] new_prob;
		logic       next_is_flag;
		logic       seq_error;
	} out_word_t;

	// inverse map from coded delta to recentering offset
	localparam logic [7:0] REMAP_TAB [255] = '{
		8'd7, 8'd20, 8'd33, 8'd46, 8'd59, 8'd72, 8'd85, 8'd98, 8'd111, 8'd124,
		8'd137, 8'd150, 8'd163, 8'd176, 8'd189, 8'd202, 8'd215, 8'd228, 8'd241, 8'd254,
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd9, 8'd10, 8'd11,
		8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd21, 8'd22,
		8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
		8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
		8'd44, 8'd45, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
		8'd55, 8'd56, 8'd57, 8'd58, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65,
		8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd73, 8'd74, 8'd75, 8'd76,
		8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd86, 8'd87,
		8'd88, 8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd96, 8'd97,
		8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd107, 8'd108,
		8'd109, 8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd125, 8'd126, 8'd127, 8'd128, 8'd129, 8'd130,
		8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139, 8'd140, 8'd141,
		8'd142, 8'd143, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149, 8'd151, 8'd152,
		8'd153, 8'd154, 8'd155, 8'd156, 8'd157, 8'd158, 8'd159, 8'd160, 8'd161, 8'd162,
		8'd164, 8'd165, 8'd166, 8'd167, 8'd168, 8'd169, 8'd170, 8'd171, 8'd172, 8'd173,
		8'd174, 8'd175, 8'd177, 8'd178, 8'd179, 8'd180, 8'd181, 8'd182, 8'd183, 8'd184,
		8'd185, 8'd186, 8'd187, 8'd188, 8'd190, 8'd191, 8'd192, 8'd193, 8'd194, 8'd195,
		8'd196, 8'd197, 8'd198, 8'd199, 8'd200, 8'd201, 8'd203, 8'd204, 8'd205, 8'd206,
		8'd207, 8'd208, 8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd216, 8'd217,
		8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd227,
		8'd229, 8'd230, 8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238,
		8'd239, 8'd240, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249,
		8'd250, 8'd251, 8'd252, 8'd253, 8'd253
	};

	// place offset v around center c, alternating below and above
	function automatic logic [7:0] pdud_recenter(logic [7:0] v, logic [7:0] c);
		logic [8:0] half_up;
		half_up = ({1'b0, v} + 9'd1) >> 1;
		if ({1'b0, v} > {c, 1'b0})
			return v;
		else if (v[0])
			return c - half_up[7:0];
		else
			return c + {1'b0, v[7:1]};
	endfunction

	// map a coded delta back to a probability near prob
	function automatic logic [7:0] pdud_remap(logic [8:0] delta, logic [7:0] prob);
		logic [7:0] p;
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] v;
		p = (prob == 8'd0) ? 8'd1 : prob;
		c = p - 8'd1;
		d = (delta > {1'b0, MAX_DELTA}) ? MAX_DELTA : delta[7:0];
		v = REMAP_TAB[d];
		if (c[7] == 1'b0)
			return 8'd1 + pdud_recenter(v, c);
		else
			return 8'd255 - pdud_recenter(v, MAX_DELTA - c);
	endfunction

endpackage

FILE: rtl/probability_delta_update_decoder.sv
// A word accepted into the input register moves to the result register once
// that register is empty or its word is taken; one word per cycle while the
// receiver keeps out_ready high. The decode of a word and the state update sit
// between the input register and the result register.
// Reset (arst_n low, asynchronous): decoder returns to idle, both pipeline
// registers empty.
module probability_delta_update_decoder import pdud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      out_valid_q;
	out_word_t out_data_q;
	out_word_t res;
	logic      adv;

	// consume the held word when the result register can take it
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	pdud_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.word   (word_s1),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	// an error word carries nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.seq_error |->
			!out_data_q.done_res && !out_data_q.next_is_flag && out_data_q.new_prob == 8'd0)
		else $error("error word with other fields set");

	// probability only travels with a completion
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.done_res |-> out_data_q.new_prob == 8'd0)
		else $error("probability without completion");

	// a held word is consumed whenever the result side drains
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_ready |-> adv)
		else $error("held word not consumed");

endmodule

FILE: rtl/pdud_core.sv
module pdud_core import pdud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  in_word_t  word,
	output out_word_t res
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_FLAG  = 4'd1;
	localparam logic [3:0] PH_PRE1  = 4'd2;
	localparam logic [3:0] PH_PRE2  = 4'd3;
	localparam logic [3:0] PH_PRE3  = 4'd4;
	localparam logic [3:0] PH_LITA  = 4'd5;
	localparam logic [3:0] PH_LITB  = 4'd6;
	localparam logic [3:0] PH_LITC  = 4'd7;
	localparam logic [3:0] PH_LIT7  = 4'd8;
	localparam logic [3:0] PH_EXTRA = 4'd9;
	localparam logic [3:0] PH_MVLIT = 4'd10;

	logic [3:0] phase_q, phase_d;
	logic [7:0] kept_prob_q, kept_prob_d;
	logic       is_mv_q, is_mv_d;
	logic [7:0] lit_q, lit_d;
	logic [2:0] bits_left_q, bits_left_d;

	logic [7:0] lit_shift;
	logic [2:0] bits_dec;
	logic [8:0] delta;
	logic       use_remap;

	assign lit_shift = {lit_q[6:0], word.bit_req};
	assign bits_dec  = bits_left_q - 3'd1;

	// decode one word: next state and result
	always_comb begin
		phase_d     = phase_q;
		kept_prob_d = kept_prob_q;
		is_mv_d     = is_mv_q;
		lit_d       = lit_q;
		bits_left_d = bits_left_q;
		res         = '0;
		delta       = '0;
		use_remap   = 1'b0;
		case (word.cmd)
			CMD_GEN, CMD_MV: begin
				kept_prob_d      = word.old_prob;
				is_mv_d          = (word.cmd == CMD_MV);
				lit_d            = '0;
				bits_left_d      = '0;
				phase_d          = PH_FLAG;
				res.next_is_flag = 1'b1;
			end
			CMD_CONT: begin
				unique case (phase_q)
					PH_FLAG: begin
						if (!word.bit_req) begin
							res.done_res = 1'b1;
							res.new_prob = kept_prob_q;
							phase_d      = PH_IDLE;
						end else if (is_mv_q) begin
							phase_d     = PH_MVLIT;
							lit_d       = '0;
							bits_left_d = 3'd7;
						end else begin
							phase_d = PH_PRE1;
						end
					end
					PH_PRE1: begin
						if (word.bit_req) begin
							phase_d = PH_PRE2;
						end else begin
							phase_d     = PH_LITA;
							lit_d       = '0;
							bits_left_d = 3'd4;
						end
					end
					PH_PRE2: begin
						if (word.bit_req) begin
							phase_d = PH_PRE3;
						end else begin
							phase_d     = PH_LITB;
							lit_d       = '0;
							bits_left_d = 3'd4;
						end
					end
					PH_PRE3: begin
						phase_d     = word.bit_req ? PH_LIT7 : PH_LITC;
						lit_d       = '0;
						bits_left_d = word.bit_req ? 3'd7 : 3'd4;
					end
					PH_LITA, PH_LITB, PH_LITC, PH_LIT7, PH_MVLIT: begin
						lit_d       = lit_shift;
						bits_left_d = bits_dec;
						if (bits_dec == 3'd0) begin
							// last literal bit: finish, or wait for the extra bit
							if (phase_q == PH_MVLIT) begin
								res.done_res = 1'b1;
								res.new_prob = {lit_shift[6:0], 1'b1};
								phase_d      = PH_IDLE;
							end else if (phase_q == PH_LIT7 && lit_shift >= 8'd65) begin
								phase_d = PH_EXTRA;
							end else begin
								use_remap = 1'b1;
								phase_d   = PH_IDLE;
								if (phase_q == PH_LITB)
									delta = {1'b0, lit_shift} + 9'd16;
								else if (phase_q == PH_LITC)
									delta = {1'b0, lit_shift} + 9'd32;
								else if (phase_q == PH_LIT7)
									delta = {1'b0, lit_shift} + 9'd64;
								else
									delta = {1'b0, lit_shift};
							end
						end
					end
					PH_EXTRA: begin
						use_remap = 1'b1;
						phase_d   = PH_IDLE;
						delta     = {lit_q, 1'b0} - 9'd1 + {8'd0, word.bit_req};
					end
					default: begin
						res.seq_error = 1'b1;
					end
				endcase
				if (use_remap) begin
					res.done_res = 1'b1;
					res.new_prob = pdud_remap(delta, kept_prob_q);
				end
			end
			default: begin
				// unused command: no change, empty result
			end
		endcase
	end

	// advance state on each consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			kept_prob_q <= '0;
			is_mv_q     <= 1'b0;
			lit_q       <= '0;
			bits_left_q <= '0;
		end else if (adv) begin
			phase_q     <= phase_d;
			kept_prob_q <= kept_prob_d;
			is_mv_q     <= is_mv_d;
			lit_q       <= lit_d;
			bits_left_q <= bits_left_d;
		end
	end

	// a start word always lands in the flag phase
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (word.cmd == CMD_GEN || word.cmd == CMD_MV) |=> phase_q == PH_FLAG)
		else $error("start word did not enter flag phase");

	// literal phases always have bits pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITA || phase_q == PH_LITB || phase_q == PH_LITC ||
		 phase_q == PH_LIT7 || phase_q == PH_MVLIT) |-> bits_left_q != 3'd0)
		else $error("literal phase with no bits left");

	// a completed update returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.done_res |=> phase_q == PH_IDLE)
		else $error("phase not idle after completion");

endmodule

FILE: tb/tb.sv
module tb;
	import pdud_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	probability_delta_update_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder state as the predictor sees it
	typedef enum logic [3:0] {
		ST_IDLE, ST_FLAG, ST_PRE1, ST_PRE2, ST_PRE3,
		ST_LITA, ST_LITB, ST_LITC, ST_LIT7, ST_EXTRA, ST_MVLIT
	} dec_state_t;

	dec_state_t  st = ST_IDLE;
	logic [7:0]  held_prob = '0;
	logic        mv_kind = 1'b0;
	logic [7:0]  lit_acc = '0;
	logic [2:0]  lit_left = '0;
	logic [7:0]  delta_tab [255];

	out_word_t   awaited_words [$];
	int          n_errors = 0;
	int          n_words = 0;
	int          n_updates = 0;
	int          n_seq_errors = 0;
	int          n_in_stalls = 0;
	int          n_sent = 0;
	int          idle_cycles = 0;
	int          rx_stall_pct = 0;
	int          rx_hold_left = 0;

	// build the inverse delta map: multiples of 13 past 7 first, then the rest in order
	initial begin
		int idx;
		for (int k = 0; k < 20; k++)
			delta_tab[k] = 8'(7 + 13 * k);
		idx = 20;
		for (int val = 1; val <= 253; val++) begin
			if (val % 13 != 7) begin
				delta_tab[idx] = 8'(val);
				idx++;
			end
		end
		delta_tab[254] = 8'd253;
	end

	function automatic int recenter_off(int v, int c);
		if (v > 2 * c)
			return v;
		if (v % 2 == 1)
			return c - (v + 1) / 2;
		return c + v / 2;
	endfunction

	// turn a coded delta into a probability near prob
	function automatic logic [7:0] map_delta(int delta, int prob);
		int c;
		int v;
		if (prob == 0)
			prob = 1;
		if (delta > 254)
			delta = 254;
		c = prob - 1;
		v = int'(delta_tab[delta]);
		if (2 * c <= 255)
			return 8'(1 + recenter_off(v, c));
		return 8'(255 - recenter_off(v, 254 - c));
	endfunction

	function automatic void enter_literal(dec_state_t s, int n);
		st = s;
		lit_acc = '0;
		lit_left = 3'(n);
	endfunction

	// advance the decoder by one word and return the result word it yields
	function automatic out_word_t step_decoder(in_word_t w);
		out_word_t r;
		r = '0;
		if (w.cmd == CMD_GEN || w.cmd == CMD_MV) begin
			held_prob = w.old_prob;
			mv_kind = (w.cmd == CMD_MV);
			lit_acc = '0;
			lit_left = '0;
			st = ST_FLAG;
			r.next_is_flag = 1'b1;
			return r;
		end
		if (w.cmd == CMD_UNUSED)
			return r;
		case (st)
			ST_FLAG: begin
				if (!w.bit_req) begin
					r.done_res = 1'b1;
					r.new_prob = held_prob;
					st = ST_IDLE;
				end else if (mv_kind) begin
					enter_literal(ST_MVLIT, 7);
				end else begin
					st = ST_PRE1;
				end
			end
			ST_PRE1: begin
				if (w.bit_req) st = ST_PRE2;
				else enter_literal(ST_LITA, 4);
			end
			ST_PRE2: begin
				if (w.bit_req) st = ST_PRE3;
				else enter_literal(ST_LITB, 4);
			end
			ST_PRE3: begin
				if (w.bit_req) enter_literal(ST_LIT7, 7);
				else enter_literal(ST_LITC, 4);
			end
			ST_LITA, ST_LITB, ST_LITC, ST_LIT7, ST_MVLIT: begin
				lit_acc = {lit_acc[6:0], w.bit_req};
				lit_left = lit_left - 3'd1;
				if (lit_left == 3'd0) begin
					r.done_res = 1'b1;
					case (st)
						ST_LITA:  r.new_prob = map_delta(int'(lit_acc), int'(held_prob));
						ST_LITB:  r.new_prob = map_delta(int'(lit_acc) + 16, int'(held_prob));
						ST_LITC:  r.new_prob = map_delta(int'(lit_acc) + 32, int'(held_prob));
						ST_MVLIT: r.new_prob = {lit_acc[6:0], 1'b1};
						default: begin
							if (lit_acc < 8'd65)
								r.new_prob = map_delta(int'(lit_acc) + 64, int'(held_prob));
							else
								r.done_res = 1'b0;
						end
					endcase
					st = r.done_res ? ST_IDLE : ST_EXTRA;
				end
			end
			ST_EXTRA: begin
				r.done_res = 1'b1;
				r.new_prob = map_delta(2 * int'(lit_acc) - 1 + int'(w.bit_req),
					int'(held_prob));
				st = ST_IDLE;
			end
			default: r.seq_error = 1'b1;
		endcase
		return r;
	endfunction

	// predict on every accepted input word
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			awaited_words.push_back(step_decoder(in_data));
		if (arst_n && in_valid && !in_ready)
			n_in_stalls++;
	end

	// compare every accepted result word with the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			n_words++;
			if (out_data.done_res) n_updates++;
			if (out_data.seq_error) n_seq_errors++;
			if (awaited_words.size() == 0) begin
				$error("result word with nothing expected: %h", out_data);
				n_errors++;
			end else begin
				want = awaited_words.pop_front();
				if (out_data.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res, out_data.done_res);
					n_errors++;
				end
				if (out_data.new_prob !== want.new_prob) begin
					$error("new_prob: expected %0d, got %0d", want.new_prob, out_data.new_prob);
					n_errors++;
				end
				if (out_data.next_is_flag !== want.next_is_flag) begin
					$error("next_is_flag: expected %0d, got %0d",
						want.next_is_flag, out_data.next_is_flag);
					n_errors++;
				end
				if (out_data.seq_error !== want.seq_error) begin
					$error("seq_error: expected %0d, got %0d", want.seq_error, out_data.seq_error);
					n_errors++;
				end
			end
		end
	end

	// receiver: long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic in_word_t word_of(logic [1:0] c, logic [7:0] p, logic b);
		in_word_t w;
		w.cmd = c;
		w.old_prob = p;
		w.bit_req = b;
		return w;
	endfunction

	function automatic in_word_t cont_word(logic b);
		return word_of(CMD_CONT, 8'($urandom_range(255)), b);
	endfunction

	task automatic idle_input(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// offer one word, hold it until accepted
	task automatic send_word(in_word_t w, int idle_pct = 0);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			idle_input($urandom_range(1, 3));
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		if (w.cmd != CMD_UNUSED)
			n_sent++;
	endtask

	task automatic wait_drained();
		idle_input(1);
		while (awaited_words.size() != 0)
			@(posedge clk);
	endtask

	// one update sequence with random content; sometimes noise or cut short
	task automatic send_sequence(int idle_pct);
		in_word_t seq [$];
		logic     is_mv;
		int       branch;
		int       nlit;
		int       lit;
		int       pct;
		pct = ($urandom_range(7) == 0) ? 0 : idle_pct;
		if ($urandom_range(99) < 8) begin
			seq.push_back(word_of(2'($urandom_range(3)), 8'($urandom_range(255)),
				1'($urandom_range(1))));
		end else begin
			is_mv = ($urandom_range(99) < 30);
			seq.push_back(word_of(is_mv ? CMD_MV : CMD_GEN, 8'($urandom_range(255)),
				1'($urandom_range(1))));
			if ($urandom_range(99) < 15) begin
				seq.push_back(cont_word(1'b0));
			end else begin
				seq.push_back(cont_word(1'b1));
				if (is_mv) begin
					nlit = 7;
				end else begin
					branch = $urandom_range(3);
					repeat (branch) seq.push_back(cont_word(1'b1));
					if (branch < 3)
						seq.push_back(cont_word(1'b0));
					nlit = (branch == 3) ? 7 : 4;
				end
				lit = $urandom_range((1 << nlit) - 1);
				for (int k = nlit - 1; k >= 0; k--)
					seq.push_back(cont_word(lit[k]));
				if (!is_mv && nlit == 7 && lit >= 65)
					seq.push_back(cont_word(1'($urandom_range(1))));
			end
			// cut some sequences short so the next word lands mid-update
			if ($urandom_range(99) < 10) begin
				branch = $urandom_range(1, seq.size());
				while (seq.size() > branch)
					void'(seq.pop_back());
			end
		end
		foreach (seq[i])
			send_word(seq[i], pct);
	endtask

	task automatic test_directed();
		rx_stall_pct = 0;
		// continue with no update running, then the unused command
		send_word(cont_word(1'b0));
		send_word(word_of(CMD_UNUSED, 8'hFF, 1'b1));
		// flag zero keeps the old probability, top value and zero
		send_word(word_of(CMD_GEN, 8'd255, 1'b0));
		send_word(cont_word(1'b0));
		send_word(word_of(CMD_GEN, 8'd0, 1'b1));
		send_word(cont_word(1'b0));
		// smallest delta at the lowest probability
		send_word(word_of(CMD_GEN, 8'd1, 1'b0));
		send_word(cont_word(1'b1));
		send_word(cont_word(1'b0));
		repeat (4) send_word(cont_word(1'b0));
		// abandon a generic update for a motion-vector one, largest literal
		send_word(word_of(CMD_GEN, 8'd1, 1'b1));
		send_word(cont_word(1'b1));
		send_word(word_of(CMD_MV, 8'd255, 1'b0));
		send_word(cont_word(1'b1));
		repeat (7) send_word(cont_word(1'b1));
		// continue right after a finished update
		send_word(cont_word(1'b1));
	endtask

	task automatic test_random(int n_items, int send_pct, int recv_pct);
		int start;
		rx_stall_pct = recv_pct;
		start = n_sent;
		while (n_sent - start < n_items)
			send_sequence(send_pct);
	endtask

	// hold the receiver off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		int start;
		rx_stall_pct = 0;
		rx_hold_left = 150;
		start = n_sent;
		while (n_sent - start < 40)
			send_sequence(0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_drained();
		test_random(450, 18, 47);
		wait_drained();
		test_random(450, 47, 18);
		test_backpressure();
		wait_drained();
		test_random(400, 0, 0);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d result words: %0d finished updates, %0d sequence errors",
			n_words, n_updates, n_seq_errors);
		$display("input held back on %0d cycles by back-pressure", n_in_stalls);
		if (n_errors == 0 && awaited_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
